// ===== sv/bdr_pkg.sv =====
`default_nettype none
package bdr_pkg;

  // surface size and height range
  localparam int COLUMNS     = 128;
  localparam int HEIGHT_BITS = 20;

  // fixed field widths
  localparam int KIND_W = 2;
  localparam int COL_W  = 8;
  localparam int CNT_W  = 8;
  localparam int NEWH_W = 20;
  localparam int Q_W    = 28;

  // derived arithmetic widths
  localparam int SUM_W = HEIGHT_BITS + $clog2(COLUMNS);
  localparam int SQ_W  = 2 * HEIGHT_BITS + $clog2(COLUMNS);
  localparam int X_W   = SQ_W + CNT_W;
  localparam int DIV_W = X_W + 16 + ((X_W + 16) % 2);
  localparam int VSR_W = 2 * CNT_W;
  localparam int RT_W  = DIV_W / 2;

  localparam logic [CNT_W-1:0] CFG_RESET = CNT_W'(99);

  // item kinds
  localparam logic [KIND_W-1:0] KIND_DEPOSIT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MEASURE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [COL_W-1:0]  column;
  } bdr_in_t;

  typedef struct packed {
    logic [NEWH_W-1:0] new_height;
    logic [Q_W-1:0]    mean_height;
    logic [Q_W-1:0]    roughness;
    logic              saturated;
    logic              bad_column;
  } bdr_out_t;

  // what the selected cell hands back
  typedef struct packed {
    logic [HEIGHT_BITS-1:0] nh;
    logic [HEIGHT_BITS-1:0] old;
    logic                   sat;
  } bdr_cell_res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bdr_unit_stat_t;

endpackage
`default_nettype wire

// ===== sv/bdr_cell.sv =====
`default_nettype none
module bdr_cell import bdr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   clr,
  input  wire logic                   sel,
  input  wire logic [HEIGHT_BITS-1:0] left,
  input  wire logic [HEIGHT_BITS-1:0] right,
  output logic      [HEIGHT_BITS-1:0] height,
  output bdr_cell_res_t               res
);

  logic [HEIGHT_BITS-1:0] h_r;
  logic [HEIGHT_BITS-1:0] h_nxt;
  logic                   grow;
  logic                   sat;

  // deposition rule: grow when on top, else stick to the higher neighbour
  always_comb begin
    grow = (h_r >= left) && (h_r >= right);
    sat  = grow && (h_r == {HEIGHT_BITS{1'b1}});
    if (grow) begin
      h_nxt = sat ? h_r : h_r + 1'b1;
    end else begin
      h_nxt = (left > right) ? left : right;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      h_r <= '0;
    end else if (sel) begin
      h_r <= h_nxt;
    end
  end

  assign height = h_r;

  // only the selected cell drives the reduction
  always_comb begin
    res = '0;
    if (sel) begin
      res.nh  = h_nxt;
      res.old = h_r;
      res.sat = sat;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bdr_div.sv =====
`default_nettype none
module bdr_div import bdr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [VSR_W-1:0] divisor,
  output logic      [DIV_W-1:0] quotient,
  output bdr_unit_stat_t        stat
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [VSR_W:0]   rem_r;
  logic [DIV_W-1:0] q_r;
  logic [VSR_W-1:0] d_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [VSR_W:0]   trial;
  logic             qbit;

  // restoring step, one quotient bit a cycle
  always_comb begin
    trial = {rem_r[VSR_W-1:0], q_r[DIV_W-1]};
    qbit  = trial >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      d_r   <= divisor;
    end else if (busy_r) begin
      rem_r <= qbit ? trial - {1'b0, d_r} : trial;
      q_r   <= {q_r[DIV_W-2:0], qbit};
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

// ===== sv/bdr_sqrt.sv =====
`default_nettype none
module bdr_sqrt import bdr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] y_in,
  output logic      [RT_W-1:0]  root,
  output bdr_unit_stat_t        stat
);

  localparam int CW = $clog2(RT_W + 1);

  logic [DIV_W-1:0] y_r;
  logic [DIV_W-1:0] r_r;
  logic [DIV_W-1:0] bit_r;
  logic [DIV_W-1:0] trial;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // digit-by-digit root, two radicand bits a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      y_r   <= y_in;
      r_r   <= '0;
      bit_r <= {2'b01, {(DIV_W-2){1'b0}}};
    end else if (busy_r) begin
      if (y_r >= trial) begin
        y_r <= y_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign root      = r_r[RT_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

// ===== sv/ballistic_deposition_roughness.sv =====
// Ballistic deposition surface with mean height and roughness.
// Input channel in_valid/in_ready/in_data carries one word per item:
// deposit, measure or clear. Output channel out_valid/out_ready/out_data
// returns exactly one word per item, in order.
// Each column height sits in its own cell of a row; a deposit selects one
// cell, which reads its two neighbours and rewrites itself.
// Steps: a deposit runs cell update, two squares, sum update and output
// register; clear, bad column, unused kinds and a measure with no active
// columns go straight to the output register; a measure runs through the
// bit-serial divider, used twice, and the two-bit-a-cycle root unit.
// One item is in work at a time: a new item is taken only once the last
// one has left the sequencer.
// in_ready is high whenever the sequencer is idle, even while a finished
// word waits in the output register. A stalled receiver holds the output
// word; the next result waits in the sequencer until the output register
// frees. cfg_we writes columns_in_use and clears the surface and the sums
// in the same cycle; write only while idle.
// Reset (rst_n low, synchronous) clears every cell and both sums and sets
// columns_in_use to 99.
`default_nettype none
module ballistic_deposition_roughness import bdr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire bdr_in_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output bdr_out_t              out_data,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_data
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_DEP  = 10'b0000000010,
    ST_SQR  = 10'b0000000100,
    ST_ACC  = 10'b0000001000,
    ST_MUL  = 10'b0000010000,
    ST_DIFF = 10'b0000100000,
    ST_DIVM = 10'b0001000000,
    ST_DIVR = 10'b0010000000,
    ST_SQRT = 10'b0100000000,
    ST_DONE = 10'b1000000000
  } state_t;

  state_t             st_r, st_nxt;
  logic [CNT_W-1:0]   cfg_r;
  logic [CNT_W-1:0]   n;
  logic [COL_W-1:0]   col_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SQ_W-1:0]    sqs_r;
  bdr_cell_res_t      dep_r;
  logic [SQ_W-1:0]    nsq_r, osq_r;
  logic [X_W-1:0]     nq_r, ss_r, x_r;
  bdr_out_t           pend_r;
  bdr_out_t           out_r;
  logic               out_valid_r;
  logic               accept;
  logic               clr_all;
  logic               in_bad;

  logic [HEIGHT_BITS-1:0] h [0:COLUMNS+1];
  logic [COLUMNS-1:0]     sel;
  bdr_cell_res_t          cres [COLUMNS];
  bdr_cell_res_t          red;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [VSR_W-1:0] div_divisor;
  logic [DIV_W-1:0] div_q;
  bdr_unit_stat_t   div_stat;
  logic             sq_start;
  logic [RT_W-1:0]  sq_root;
  bdr_unit_stat_t   sq_stat;

  assign n        = (cfg_r > CNT_W'(COLUMNS)) ? CNT_W'(COLUMNS) : cfg_r;
  assign in_ready = (st_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign clr_all  = cfg_we || (accept && in_data.kind == KIND_CLEAR);

  // deposit outside the active columns
  assign in_bad = (in_data.kind == KIND_DEPOSIT) &&
                  (in_data.column < COL_W'(1) || in_data.column > COL_W'(n));

  // row of cells, edges read as zero
  assign h[0]         = '0;
  assign h[COLUMNS+1] = '0;

  for (genvar i = 0; i < COLUMNS; i++) begin : g_cell
    assign sel[i] = (st_r == ST_DEP) && (col_r == COL_W'(i + 1));
    bdr_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .clr    (clr_all),
      .sel    (sel[i]),
      .left   (h[i]),
      .right  (h[i+2]),
      .height (h[i+1]),
      .res    (cres[i])
    );
  end

  // gather the selected cell's word
  always_comb begin
    red = '0;
    for (int i = 0; i < COLUMNS; i++) begin
      red = red | cres[i];
    end
  end

  // shared divider: mean first, then the variance scaled by 2^16
  assign div_start = (st_r == ST_DIFF) || (st_r == ST_DIVM && div_stat.done);
  always_comb begin
    if (st_r == ST_DIFF) begin
      div_dividend = DIV_W'({sum_r, 8'b0});
      div_divisor  = VSR_W'(n);
    end else begin
      div_dividend = DIV_W'({x_r, 16'b0});
      div_divisor  = VSR_W'(n * n);
    end
  end

  bdr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .stat     (div_stat)
  );

  assign sq_start = (st_r == ST_DIVR) && div_stat.done;

  bdr_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .y_in  (div_q),
    .root  (sq_root),
    .stat  (sq_stat)
  );

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.kind == KIND_DEPOSIT) begin
            st_nxt = in_bad ? ST_DONE : ST_DEP;
          end else if (in_data.kind == KIND_MEASURE) begin
            st_nxt = (n == '0) ? ST_DONE : ST_MUL;
          end else begin
            st_nxt = ST_DONE;
          end
        end
      end
      ST_DEP:  st_nxt = ST_SQR;
      ST_SQR:  st_nxt = ST_ACC;
      ST_ACC:  st_nxt = ST_DONE;
      ST_MUL:  st_nxt = ST_DIFF;
      ST_DIFF: st_nxt = ST_DIVM;
      ST_DIVM: if (div_stat.done) st_nxt = ST_DIVR;
      ST_DIVR: if (div_stat.done) st_nxt = ST_SQRT;
      ST_SQRT: if (sq_stat.done) st_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_data;
    end
  end

  // running sums
  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      sum_r <= '0;
      sqs_r <= '0;
    end else if (st_r == ST_ACC) begin
      sum_r <= sum_r + SUM_W'(dep_r.nh) - SUM_W'(dep_r.old);
      sqs_r <= sqs_r + nsq_r - osq_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      col_r  <= in_data.column;
      pend_r <= bdr_out_t'({{(NEWH_W + 2*Q_W + 1){1'b0}}, in_bad});
    end
    if (st_r == ST_DEP) begin
      dep_r <= red;
    end
    if (st_r == ST_SQR) begin
      nsq_r <= SQ_W'(dep_r.nh * dep_r.nh);
      osq_r <= SQ_W'(dep_r.old * dep_r.old);
    end
    if (st_r == ST_ACC) begin
      pend_r.new_height <= NEWH_W'(dep_r.nh);
      pend_r.saturated  <= dep_r.sat;
    end
    if (st_r == ST_MUL) begin
      nq_r <= X_W'(n * sqs_r);
      ss_r <= X_W'(sum_r * sum_r);
    end
    if (st_r == ST_DIFF) begin
      x_r <= nq_r - ss_r;
    end
    if (st_r == ST_DIVM && div_stat.done) begin
      pend_r.mean_height <= div_q[Q_W-1:0];
    end
    if (st_r == ST_SQRT && sq_stat.done) begin
      pend_r.roughness <= sq_root[Q_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == ST_DONE && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_DONE && (!out_valid_r || out_ready)) begin
      out_r <= pend_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_one_cell: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel)) else $error("more than one cell selected");

  a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.bad_column |-> out_r.new_height == '0 && !out_r.saturated)
    else $error("bad column word carries a height");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.saturated |-> out_r.new_height == NEWH_W'({HEIGHT_BITS{1'b1}}))
    else $error("saturated word without maximum height");

  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_IDLE |-> !div_stat.busy && !sq_stat.busy)
    else $error("arithmetic unit busy while idle");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdr_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int HMAX = (1 << HEIGHT_BITS) - 1;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 400;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  bdr_in_t in_data;
  logic out_valid;
  logic out_ready;
  bdr_out_t out_data;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_data;

  ballistic_deposition_roughness uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // predictor state
  longint unsigned surf_h[COLUMNS];
  longint unsigned surf_sum;
  longint unsigned surf_sq;
  int unsigned active_cols;

  bdr_out_t pending_words[$];
  int errors;
  int cycles;
  int long_hold;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic void wipe_surface();
    for (int i = 0; i < COLUMNS; i++) surf_h[i] = 0;
    surf_sum = 0;
    surf_sq = 0;
  endfunction

  function automatic longint unsigned int_root(longint unsigned y);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > y) b >>= 2;
    while (b != 0) begin
      if (y >= r + b) begin
        y -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // expected word for one item, updates the surface
  function automatic bdr_out_t grow_surface(bdr_in_t it);
    bdr_out_t r;
    longint unsigned n, old, lft, rgt, nh, x, nn, q, rm, y;
    int c;
    r = '0;
    n = (active_cols < COLUMNS) ? active_cols : COLUMNS;
    c = it.column;
    case (it.kind)
      KIND_DEPOSIT: begin
        if (c < 1 || c > n) begin
          r.bad_column = 1'b1;
        end else begin
          old = surf_h[c-1];
          lft = (c >= 2) ? surf_h[c-2] : 0;
          rgt = (c + 1 <= n) ? surf_h[c] : 0;
          if (old >= lft && old >= rgt) begin
            if (old >= HMAX) begin
              nh = HMAX;
              r.saturated = 1'b1;
            end else begin
              nh = old + 1;
            end
          end else begin
            nh = (lft > rgt) ? lft : rgt;
          end
          surf_h[c-1] = nh;
          surf_sum += nh - old;
          surf_sq += nh * nh - old * old;
          r.new_height = nh[NEWH_W-1:0];
        end
      end
      KIND_MEASURE: begin
        if (n != 0) begin
          x = (surf_sum << 8) / n;
          r.mean_height = x[Q_W-1:0];
          x = n * surf_sq - surf_sum * surf_sum;
          nn = n * n;
          q = x / nn;
          rm = x % nn;
          y = (q << 16) + ((rm << 16) / nn);
          x = int_root(y);
          r.roughness = x[Q_W-1:0];
        end
      end
      KIND_CLEAR: wipe_surface();
      default: ;
    endcase
    return r;
  endfunction

  // result checking and receiver stalls
  initial begin
    int gap;
    out_ready = 1'b0;
    errors = 0;
    long_hold = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          $error("unexpected word %h", out_data);
          errors++;
        end else begin
          bdr_out_t e;
          e = pending_words.pop_front();
          if (e.new_height !== out_data.new_height) begin
            $error("new_height exp %0d got %0d", e.new_height, out_data.new_height);
            errors++;
          end
          if (e.mean_height !== out_data.mean_height) begin
            $error("mean_height exp %0d got %0d", e.mean_height, out_data.mean_height);
            errors++;
          end
          if (e.roughness !== out_data.roughness) begin
            $error("roughness exp %0d got %0d", e.roughness, out_data.roughness);
            errors++;
          end
          if (e.saturated !== out_data.saturated) begin
            $error("saturated exp %0d got %0d", e.saturated, out_data.saturated);
            errors++;
          end
          if (e.bad_column !== out_data.bad_column) begin
            $error("bad_column exp %0d got %0d", e.bad_column, out_data.bad_column);
            errors++;
          end
        end
      end
      // long hold requested by the sender side
      if (long_hold > 0) begin
        out_ready <= 1'b0;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
        out_ready <= 1'b1;
      end else begin
        gap = $urandom_range(0, 9);
        if (gap < 6) out_ready <= 1'b1;
        else if (gap < 9) out_ready <= 1'b0;
        else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(5, 40)) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // valid stays high into the next word unless a gap follows
  task automatic send_word(bdr_in_t it);
    int g;
    g = $urandom_range(0, 15);
    if (g == 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(10, 60)) @(posedge clk);
    end else if (g > 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pending_words.push_back(grow_surface(it));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cols(logic [CNT_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_cols = {24'd0, v};
    wipe_surface();
  endtask

  function automatic bdr_in_t rand_word(int unsigned n);
    bdr_in_t it;
    int p;
    p = $urandom_range(0, 99);
    it.column = (n > 0) ? COL_W'($urandom_range(1, n)) : COL_W'(1);
    if (p < 85) it.kind = KIND_DEPOSIT;
    else if (p < 93) it.kind = KIND_MEASURE;
    else if (p < 95) it.kind = KIND_CLEAR;
    else if (p < 97) it.kind = KIND_UNUSED;
    else begin
      it.kind = KIND_DEPOSIT;
      it.column = COL_W'($urandom_range(0, 255));
    end
    return it;
  endfunction

  typedef struct {
    bdr_in_t  stim;
    logic     has_exp;
    bdr_out_t exp_word;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    bdr_in_t it;
    int unsigned cfgs[4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    active_cols = 99;
    wipe_surface();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: known answers where obvious
    rows.push_back('{'{KIND_MEASURE, 8'd0}, 1'b1, '0});
    rows.push_back('{'{KIND_DEPOSIT, 8'd0}, 1'b1, '{0, 0, 0, 1'b0, 1'b1}});
    rows.push_back('{'{KIND_DEPOSIT, 8'd100}, 1'b1, '{0, 0, 0, 1'b0, 1'b1}});
    rows.push_back('{'{KIND_DEPOSIT, 8'd255}, 1'b1, '{0, 0, 0, 1'b0, 1'b1}});
    rows.push_back('{'{KIND_DEPOSIT, 8'd1}, 1'b1, '{20'd1, 0, 0, 1'b0, 1'b0}});
    rows.push_back('{'{KIND_DEPOSIT, 8'd2}, 1'b0, '0});
    rows.push_back('{'{KIND_DEPOSIT, 8'd99}, 1'b0, '0});
    rows.push_back('{'{KIND_DEPOSIT, 8'd98}, 1'b0, '0});
    rows.push_back('{'{KIND_DEPOSIT, 8'd50}, 1'b0, '0});
    rows.push_back('{'{KIND_DEPOSIT, 8'd51}, 1'b0, '0});
    rows.push_back('{'{KIND_MEASURE, 8'hFF}, 1'b0, '0});
    rows.push_back('{'{KIND_UNUSED, 8'hAA}, 1'b1, '0});
    rows.push_back('{'{KIND_CLEAR, 8'h55}, 1'b1, '0});
    rows.push_back('{'{KIND_MEASURE, 8'd0}, 1'b1, '0});
    foreach (rows[i]) begin
      send_word(rows[i].stim);
      if (rows[i].has_exp) pending_words[$] = rows[i].exp_word;
    end

    // full column range, a column pile-up, then zero columns
    write_cols(8'd128);
    send_word('{KIND_DEPOSIT, 8'd128});
    send_word('{KIND_DEPOSIT, 8'd129});
    repeat (20) send_word('{KIND_DEPOSIT, 8'd64});
    send_word('{KIND_MEASURE, 8'd0});
    write_cols(8'd0);
    send_word('{KIND_DEPOSIT, 8'd1});
    send_word('{KIND_MEASURE, 8'd0});

    // receiver holds off while the sender keeps offering
    write_cols(8'd2);
    long_hold = 300;
    for (int i = 0; i < 8; i++) send_word(rand_word(2));
    wait_drained();

    // random phases over several sizes, extremes included
    cfgs = '{3, 255, 17, 2};
    foreach (cfgs[k]) begin
      write_cols(cfgs[k][CNT_W-1:0]);
      for (int i = 0; i < 110; i++) begin
        it = rand_word((cfgs[k] < COLUMNS) ? cfgs[k] : COLUMNS);
        it.column ^= 8'($urandom_range(0, 1) << $urandom_range(0, 7)) & {8{i % 37 == 0}};
        send_word(it);
      end
      send_word('{KIND_MEASURE, 8'd0});
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
